// File: design/ssp_pkg.sv
`timescale 1ns / 1ps

package ssp_pkg;

  localparam int unsigned TagW = 32;
  localparam int unsigned AgeW = 8;
  localparam int unsigned SevW = 2;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STAT_PUSHED  = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_INVALID = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_SERVED  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [TagW-1:0]  tag;
    logic [AgeW-1:0]  age;
    logic [SevW-1:0]  severity;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [TagW-1:0]  out_tag;
    logic [AgeW-1:0]  out_age;
    logic [SevW-1:0]  out_severity;
  } out_t;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [AgeW-1:0]  age;
    logic [SevW-1:0]  severity;
  } entry_t;

  // Result handshake between the engine and the output register.
  typedef struct packed {
    logic  valid;
    out_t  data;
  } res_t;

endpackage

// File: design/ssp_engine.sv
`timescale 1ns / 1ps

module ssp_engine import ssp_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  output res_t  res_o,
  input  logic  res_ready_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;

  logic [CW-1:0] count_q;
  logic [AW-1:0] cur_idx_q;
  logic [AW-1:0] best_idx_q;
  logic          first_q;
  entry_t        top_q;
  entry_t        best_q;
  out_t          res_q;

  entry_t        mem_q [DEPTH];
  entry_t        rdata_q;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  logic    in_xfer;
  logic    is_pop;
  logic    is_full;
  logic    is_empty;
  logic    push_ok;
  logic    scan_last;
  logic    take;
  status_e idle_status;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign is_pop    = (in_data_i.op == OP_POP);
  assign is_full   = (count_q == CW'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign push_ok   = !is_pop && !is_full && (in_data_i.severity != '0);
  assign scan_last = (cur_idx_q == '0);
  // Strict compare keeps ties on the entry nearest the top.
  assign take      = first_q || (rdata_q.severity > best_q.severity);

  // Status of an item that finishes without a scan; full wins over a zero severity.
  always_comb begin
    if (is_pop) begin
      idle_status = STAT_EMPTY;
    end else if (is_full) begin
      idle_status = STAT_FULL;
    end else if (in_data_i.severity == '0) begin
      idle_status = STAT_INVALID;
    end else begin
      idle_status = STAT_PUSHED;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (is_pop && !is_empty) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_SWAP;
        end
      end
      ST_SWAP: state_d = ST_RESP;
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and memory port control.
  always_comb begin
    in_ready_o = 1'b0;
    res_o      = '{valid: 1'b0, data: res_q};
    we         = 1'b0;
    waddr      = count_q[AW-1:0];
    wdata      = '{tag: in_data_i.tag, age: in_data_i.age, severity: in_data_i.severity};
    raddr      = AW'(count_q - CW'(1));
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        we         = in_xfer && push_ok;
      end
      ST_SCAN: begin
        raddr = cur_idx_q - AW'(1);
      end
      ST_SWAP: begin
        // Move the old top down into the slot of the served entry.
        we    = 1'b1;
        waddr = best_idx_q;
        wdata = top_q;
      end
      ST_RESP: begin
        res_o.valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // A push write and the first scan read never fall in the same cycle.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && in_xfer) begin
        first_q <= 1'b1;
        if (push_ok) begin
          count_q <= count_q + CW'(1);
        end
      end
      if (state_q == ST_SCAN) begin
        first_q <= 1'b0;
      end
      if (state_q == ST_SWAP) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cur_idx_q <= AW'(count_q - CW'(1));
          res_q     <= '{status: idle_status, out_tag: '0, out_age: '0, out_severity: '0};
        end
      end
      ST_SCAN: begin
        if (first_q) begin
          top_q <= rdata_q;
        end
        if (take) begin
          best_q     <= rdata_q;
          best_idx_q <= cur_idx_q;
        end
        cur_idx_q <= cur_idx_q - AW'(1);
      end
      ST_SWAP: begin
        res_q <= '{status: STAT_SERVED, out_tag: best_q.tag, out_age: best_q.age,
                   out_severity: best_q.severity};
      end
      default: ;
    endcase
  end

endmodule

// File: design/severity_priority_stack.sv
`timescale 1ns / 1ps

// Severity priority stack: a bounded stack of DEPTH entries (tag, age, severity) held in
// a single-port-write, registered-read memory. Push, a refused push and a pop on an empty
// stack go from the idle state straight to the response state. A pop reads every stored
// entry from the top down through the one read port, one per cycle, then writes the old
// top into the served slot before it responds. The result sits in an output register, so
// one more item can be taken while it waits. Memory contents need no clearing after reset;
// only values read from slots below the count are used.
module severity_priority_stack import ssp_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output out_t  out_data_o
);

  res_t res;
  logic res_ready;
  logic out_valid_q;
  out_t out_data_q;

  assign res_ready = !out_valid_q || out_ready_i;

  ssp_engine #(
    .DEPTH(DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_data_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: design/ssp_checker.sv
`timescale 1ns / 1ps

module ssp_checker import ssp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // One item at a time: a transfer closes the input until its work is done.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STAT_SERVED |->
      out_data_o.out_tag == '0 && out_data_o.out_age == '0 &&
      out_data_o.out_severity == '0)
    else $error("payload fields set on a non-served result");

  a_served_sev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_SERVED |-> out_data_o.out_severity != '0)
    else $error("served entry carries severity zero");

endmodule

bind severity_priority_stack ssp_checker u_ssp_checker (.*);

// File: tb/severity_priority_stack_tb.sv
`timescale 1ns / 1ps

module severity_priority_stack_tb;
  import ssp_pkg::*;

  localparam int unsigned DEPTH        = 128;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 64;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  // Set for the closing stretch: no idling on either side.
  bit          no_idle   = 1'b0;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  // Predicted stack contents and the results still owed by the block.
  entry_t      stack_mem [DEPTH];
  int unsigned stack_cnt = 0;
  out_t        pending_results [$];

  severity_priority_stack #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  // Apply one item to the predicted stack and return the result it must produce.
  function automatic out_t serve_or_store(in_t item);
    out_t   res;
    entry_t held;
    int     top;
    int     best;
    res = '0;
    if (item.op == OP_PUSH) begin
      if (stack_cnt == DEPTH) begin
        res.status = STAT_FULL;
      end else if (item.severity == '0) begin
        res.status = STAT_INVALID;
      end else begin
        stack_mem[stack_cnt] = '{tag: item.tag, age: item.age, severity: item.severity};
        stack_cnt++;
        res.status = STAT_PUSHED;
      end
    end else if (stack_cnt == 0) begin
      res.status = STAT_EMPTY;
    end else begin
      top  = stack_cnt - 1;
      best = top;
      // Scan downward; strict compare keeps ties nearest the top.
      for (int i = top - 1; i >= 0; i--) begin
        if (stack_mem[i].severity > stack_mem[best].severity) best = i;
      end
      held            = stack_mem[best];
      stack_mem[best] = stack_mem[top];
      stack_mem[top]  = held;
      stack_cnt       = top;
      res.status       = STAT_SERVED;
      res.out_tag      = held.tag;
      res.out_age      = held.age;
      res.out_severity = held.severity;
    end
    return res;
  endfunction

  function automatic in_t rand_item(int unsigned push_pct, int unsigned zero_sev_pct);
    in_t item;
    item.op       = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    item.tag      = $urandom();
    item.age      = 8'($urandom_range(0, 255));
    item.severity = ($urandom_range(0, 99) < zero_sev_pct) ? 2'd0 : 2'($urandom_range(1, 3));
    return item;
  endfunction

  function automatic in_t make_item(op_e op, logic [TagW-1:0] tag, logic [AgeW-1:0] age,
                                    logic [SevW-1:0] sev);
    in_t item;
    item.op       = op;
    item.tag      = tag;
    item.age      = age;
    item.severity = sev;
    return item;
  endfunction

  // Hold valid until the transfer; an idle gap drops valid only after the previous one.
  task automatic send_item(in_t item);
    int unsigned gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic test_directed();
    send_item(make_item(OP_POP,  32'hFFFF_FFFF, 8'hFF, 2'd3));  // pop on empty
    send_item(make_item(OP_PUSH, 32'hFFFF_FFFF, 8'hFF, 2'd0));  // zero severity
    send_item(make_item(OP_PUSH, 32'h0000_0000, 8'h00, 2'd1));
    send_item(make_item(OP_PUSH, 32'hFFFF_FFFF, 8'hFF, 2'd3));
    send_item(make_item(OP_PUSH, 32'h0000_1111, 8'h01, 2'd2));
    send_item(make_item(OP_PUSH, 32'h0000_2222, 8'h02, 2'd2));
    send_item(make_item(OP_PUSH, 32'h0000_3333, 8'h03, 2'd1));
    // Severe entry sits deep: it must be swapped with the top before removal.
    send_item(make_item(OP_POP,  32'h0, 8'h0, 2'd0));
    // Ties among severity 2, then among severity 1: nearest the top wins.
    send_item(make_item(OP_POP,  32'hA5A5_A5A5, 8'h5A, 2'd1));
    send_item(make_item(OP_POP,  32'h0, 8'h0, 2'd2));
    send_item(make_item(OP_POP,  32'h0, 8'h0, 2'd3));
    send_item(make_item(OP_POP,  32'h0, 8'h0, 2'd0));
    send_item(make_item(OP_POP,  32'h0, 8'h0, 2'd0));          // empty again
    send_item(make_item(OP_PUSH, 32'h8000_0001, 8'h80, 2'd3));
    send_item(make_item(OP_PUSH, 32'h7FFF_FFFE, 8'h7F, 2'd0)); // zero severity, not empty
    send_item(make_item(OP_POP,  32'h0, 8'h0, 2'd0));
  endtask

  // Fill every slot, push past full (zero severity too), then drain past empty.
  task automatic test_fill_and_drain();
    for (int i = 0; i < DEPTH; i++) send_item(rand_item(100, 0));
    send_item(rand_item(100, 0));
    send_item(make_item(OP_PUSH, $urandom(), 8'($urandom_range(0, 255)), 2'd0));
    send_item(rand_item(100, 0));
    for (int i = 0; i < DEPTH + 2; i++) send_item(rand_item(0, 25));
  endtask

  // Segments with a push bias move the fill level up and down across its range.
  task automatic test_random_mix();
    int unsigned sent;
    int unsigned seg_len;
    int unsigned push_pct;
    sent = 0;
    while (sent < 300) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      for (int i = 0; i < seg_len; i++) send_item(rand_item(push_pct, 8));
      sent += seg_len;
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int i = 0; i < 70; i++) send_item(rand_item(55, 8));
  endtask

  // Compare each result transfer against the oldest prediction, then record new items.
  always @(posedge clk) begin : scoreboard
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none, actual status %0d tag %h age %h sev %0d",
                 $time, out_data.status, out_data.out_tag, out_data.out_age,
                 out_data.out_severity);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          err_cnt++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_data.status);
        end
        if (out_data.out_tag !== want.out_tag) begin
          err_cnt++;
          $display("%0t: out_tag mismatch, expected %h, actual %h",
                   $time, want.out_tag, out_data.out_tag);
        end
        if (out_data.out_age !== want.out_age) begin
          err_cnt++;
          $display("%0t: out_age mismatch, expected %h, actual %h",
                   $time, want.out_age, out_data.out_age);
        end
        if (out_data.out_severity !== want.out_severity) begin
          err_cnt++;
          $display("%0t: out_severity mismatch, expected %0d, actual %0d",
                   $time, want.out_severity, out_data.out_severity);
        end
      end
    end
    if (rst_n && in_valid && in_ready) pending_results.push_back(serve_or_store(in_data));
  end

  // Output side: stall in random bursts until the closing stretch.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 17);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[severity_priority_stack] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed();
    test_fill_and_drain();
    test_random_mix();
    test_back_to_back();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("[severity_priority_stack] OK");
    end else begin
      $display("[severity_priority_stack] ERROR");
    end
    $finish;
  end

endmodule
